// ===== src/wsd_pkg.sv =====
// Shared types, constants and helper functions for the WebSocket frame deframer.
// Depends on nothing; every other file of the block uses it.
package wsd_pkg;

   typedef logic [7:0] octet_type;
   typedef logic [3:0] opcode_type;
   typedef logic [1:0] kind_type;
   typedef logic [1:0] err_type;
   typedef logic [63:0] len_type;
   typedef logic [31:0] key_type;
   typedef logic [2:0] count_type;
   typedef logic [1:0] key_idx_type;

   typedef enum logic [2:0] {
      PH_HEAD0   = 3'd0,
      PH_HEAD1   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_HALT    = 3'd5
   } phase_type;

   localparam kind_type KIND_PAYLOAD = 2'd0;
   localparam kind_type KIND_EMPTY   = 2'd1;
   localparam kind_type KIND_ERROR   = 2'd2;

   localparam err_type ERR_NONE         = 2'd0;
   localparam err_type ERR_UNKNOWN_OP   = 2'd1;
   localparam err_type ERR_UNEXPECTED_C = 2'd2;

   localparam opcode_type OP_CONT   = 4'd0;
   localparam opcode_type OP_TEXT   = 4'd1;
   localparam opcode_type OP_BINARY = 4'd2;
   localparam opcode_type OP_CLOSE  = 4'd8;
   localparam opcode_type OP_PING   = 4'd9;
   localparam opcode_type OP_PONG   = 4'd10;

   localparam logic [6:0] LEN7_MAX   = 7'd125;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;

   // The length counter always finishes at its top value: a 16-bit length
   // starts at six and so counts only two octets, a 64-bit length starts at zero.
   localparam count_type CNT_EXT16_START = 3'd6;
   localparam count_type CNT_EXT_LAST    = 3'd7;
   localparam count_type CNT_KEY_LAST    = 3'd3;

   typedef struct packed {
      kind_type   result_kind;
      octet_type  out_octet;
      opcode_type frame_opcode;
      logic       frame_last;
      logic       message_last;
      err_type    fault_code;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } step_type;

   function automatic logic is_data(input opcode_type op);
      return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
   endfunction

   function automatic logic known_opcode(input opcode_type op);
      return is_data(op) || (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

   // The first key octet sits in the top byte of the key word.
   function automatic octet_type key_octet(input key_type key, input key_idx_type idx);
      octet_type k;
      case (idx)
         2'd0: k = key[31:24];
         2'd1: k = key[23:16];
         2'd2: k = key[15:8];
         2'd3: k = key[7:0];
         default: k = key[31:24];
      endcase
      return k;
   endfunction

endpackage

// ===== src/wsd_req_if.sv =====
// Input channel of the deframer: one raw stream octet per transaction.
// Depends on wsd_pkg for the payload type.
interface wsd_req_if;
   logic               valid;
   logic               ready;
   wsd_pkg::octet_type in_octet;

   modport source (output valid, output in_octet, input ready);
   modport sink (input valid, input in_octet, output ready);
endinterface

// ===== src/wsd_rsp_if.sv =====
// Result channel of the deframer: one decoded result per transaction.
// Depends on wsd_pkg for the payload types.
interface wsd_rsp_if;
   logic                valid;
   logic                ready;
   wsd_pkg::kind_type   result_kind;
   wsd_pkg::octet_type  out_octet;
   wsd_pkg::opcode_type frame_opcode;
   logic                frame_last;
   logic                message_last;
   wsd_pkg::err_type    fault_code;

   modport source (output valid, output result_kind, output out_octet, output frame_opcode,
                   output frame_last, output message_last, output fault_code, input ready);
   modport sink (input valid, input result_kind, input out_octet, input frame_opcode,
                 input frame_last, input message_last, input fault_code, output ready);
endinterface

// ===== src/wsd_parser.sv =====
// Frame header parser and payload unmasker: holds the framing state and turns
// one octet into at most one result per step. Depends on wsd_pkg.
module wsd_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  wsd_pkg::octet_type  octet,
   output wsd_pkg::step_type   res
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   count_type   cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   opcode_type  op_ff, op_in;
   logic        mask_ff, mask_in;
   len_type     rlen_ff, rlen_in;
   key_type     key_ff, key_in;
   key_idx_type idx_ff, idx_in;
   logic        msg_open_ff, msg_open_in;

   logic        hdr_done;
   len_type     hdr_len;
   logic [6:0]  len7;
   len_type     rlen_dec;
   logic        pay_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD0;
         cnt_ff      <= '0;
         fin_ff      <= 1'b0;
         op_ff       <= '0;
         mask_ff     <= 1'b0;
         rlen_ff     <= '0;
         key_ff      <= '0;
         idx_ff      <= '0;
         msg_open_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         fin_ff      <= fin_in;
         op_ff       <= op_in;
         mask_ff     <= mask_in;
         rlen_ff     <= rlen_in;
         key_ff      <= key_in;
         idx_ff      <= idx_in;
         msg_open_ff <= msg_open_in;
      end
   end

   assign len7     = octet[6:0];
   assign rlen_dec = rlen_ff - 64'd1;
   assign pay_last = (rlen_dec == '0);

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      fin_in      = fin_ff;
      op_in       = op_ff;
      mask_in     = mask_ff;
      rlen_in     = rlen_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      msg_open_in = msg_open_ff;
      hdr_done    = 1'b0;
      hdr_len     = rlen_ff;
      res         = '0;

      case (phase_ff)
         PH_HEAD0: begin
            fin_in = octet[7];
            op_in  = octet[3:0];
            key_in = '0;
            idx_in = '0;
            cnt_in = '0;
            if (!known_opcode(octet[3:0])) begin
               phase_in                = PH_HALT;
               res.valid               = 1'b1;
               res.rsp.result_kind     = KIND_ERROR;
               res.rsp.frame_opcode    = octet[3:0];
               res.rsp.fault_code      = ERR_UNKNOWN_OP;
            end else if ((octet[3:0] == OP_CONT) && !msg_open_ff) begin
               phase_in                = PH_HALT;
               res.valid               = 1'b1;
               res.rsp.result_kind     = KIND_ERROR;
               res.rsp.frame_opcode    = octet[3:0];
               res.rsp.fault_code      = ERR_UNEXPECTED_C;
            end else begin
               phase_in = PH_HEAD1;
            end
         end
         PH_HEAD1: begin
            mask_in = octet[7];
            if (len7 <= LEN7_MAX) begin
               rlen_in = 64'(len7);
               if (octet[7]) begin
                  cnt_in   = '0;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
                  hdr_len  = 64'(len7);
               end
            end else begin
               rlen_in  = '0;
               cnt_in   = (len7 == LEN7_EXT16) ? CNT_EXT16_START : '0;
               phase_in = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            rlen_in = {rlen_ff[55:0], octet};
            if (cnt_ff != CNT_EXT_LAST) begin
               cnt_in = cnt_ff + 3'd1;
            end else begin
               cnt_in = '0;
               if (mask_ff) begin
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
                  hdr_len  = {rlen_ff[55:0], octet};
               end
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], octet};
            if (cnt_ff != CNT_KEY_LAST) begin
               cnt_in = cnt_ff + 3'd1;
            end else begin
               cnt_in   = '0;
               hdr_done = 1'b1;
               hdr_len  = rlen_ff;
            end
         end
         PH_PAYLOAD: begin
            idx_in  = idx_ff + 2'd1;
            rlen_in = rlen_dec;
            if (pay_last) begin
               phase_in = PH_HEAD0;
            end
            if (is_data(op_ff)) begin
               if (pay_last) begin
                  msg_open_in = !fin_ff;
               end
               res.valid                = 1'b1;
               res.rsp.result_kind      = KIND_PAYLOAD;
               res.rsp.out_octet        = octet ^ key_octet(key_ff, idx_ff);
               res.rsp.frame_opcode     = op_ff;
               res.rsp.frame_last       = pay_last;
               res.rsp.message_last     = pay_last && fin_ff;
               res.rsp.fault_code       = ERR_NONE;
            end
         end
         default: begin
            // Halted, and the unused phase codes: octets are swallowed.
         end
      endcase

      if (hdr_done) begin
         idx_in = '0;
         if (hdr_len != '0) begin
            phase_in = PH_PAYLOAD;
         end else begin
            phase_in = PH_HEAD0;
            if (is_data(op_ff)) begin
               msg_open_in          = !fin_ff;
               res.valid            = 1'b1;
               res.rsp.result_kind  = KIND_EMPTY;
               res.rsp.frame_opcode = op_ff;
               res.rsp.frame_last   = 1'b1;
               res.rsp.message_last = fin_ff;
               res.rsp.fault_code   = ERR_NONE;
            end
         end
      end
   end

endmodule

// ===== src/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if and wsd_frame_core.

// The deframer takes one stream octet per cycle while its output is not stalled
// and gives at most one result per octet: an unmasked payload octet of a text,
// binary or continuation frame, an end marker for an empty data frame, or a
// protocol error. Throughput is one transaction per cycle in steady state while
// the consumer takes results; the per-octet work is a single parser step whose
// widest path is the 64-bit remaining-length decrement and zero test. An accepted
// input transaction is captured in an input register; the parser then updates its
// framing state and writes the result register, which drives the output. Octets
// that produce no result (header bytes, extended length, masking key, control
// frame payload) still take a parser step each. The input register accepts a new
// octet while a finished result waits to be taken, if it holds none itself, and a
// stalled consumer costs no bubble when it resumes: the held octet moves into the
// result register in the same cycle the waiting result is taken. Close, ping and
// pong payloads are consumed silently. After an unknown opcode, or a continuation
// frame with no open message, one error result is issued and the block drops
// every further octet until reset. There is no memory and no clearing pass.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);
   import wsd_pkg::*;

   logic      in_valid_ff, in_valid_in;
   octet_type in_octet_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_rsp_ff;

   logic      advance;
   step_type  step_res;

   // The parser consumes the held octet whenever the result register is free
   // or is being emptied in this cycle.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_octet_ff <= req_chan.in_octet;
      end
   end

   wsd_frame_core u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .octet (in_octet_ff),
      .res   (step_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_res.valid;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.valid) begin
         out_rsp_ff <= step_res.rsp;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_kind  = out_rsp_ff.result_kind;
   assign rsp_chan.out_octet    = out_rsp_ff.out_octet;
   assign rsp_chan.frame_opcode = out_rsp_ff.frame_opcode;
   assign rsp_chan.frame_last   = out_rsp_ff.frame_last;
   assign rsp_chan.message_last = out_rsp_ff.message_last;
   assign rsp_chan.fault_code   = out_rsp_ff.fault_code;

`ifndef SYNTH
   // An error result never closes a frame or a message and always carries a code.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_rsp_ff.result_kind == KIND_ERROR) |->
         !out_rsp_ff.frame_last && !out_rsp_ff.message_last &&
         (out_rsp_ff.fault_code != ERR_NONE))
      else $error("error result with frame flags or without a code");

   // A message can only end where a frame ends.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.message_last |-> out_rsp_ff.frame_last)
      else $error("message end without frame end");

   // Only payload results carry an octet; an empty frame result always ends its frame.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_rsp_ff.result_kind != KIND_PAYLOAD) |->
         (out_rsp_ff.out_octet == '0) &&
         ((out_rsp_ff.result_kind != KIND_EMPTY) || out_rsp_ff.frame_last))
      else $error("non-payload result carries an octet or empty frame not ended");

   // A held octet that the parser did not take is still held next cycle.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_octet_ff))
      else $error("input register lost a pending octet");

   // A result waiting on a stalled consumer is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_rsp_ff))
      else $error("result register overwritten while stalled");
`endif

endmodule
